>>> design/spc_pkg.sv
// ----------------------------------------------------------------------------
// Semiprime range counter package
// Shared types and codes for the semiprime range counter.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BOUNDS  = 2'd1;
    localparam logic [1:0] STATUS_UNBUILT = 2'd2;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Upper limit after reset, before it is clamped to the store size.
    localparam int RESET_LIMIT = 65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_OUTER_RD,
        ST_OUTER_CHK,
        ST_INNER_RD,
        ST_INNER_WR,
        ST_PFX_RD,
        ST_PFX_CO,
        ST_PFX_CF,
        ST_PFX_CHK,
        ST_PFX_WR,
        ST_Q_RD_HI,
        ST_Q_RD_LO,
        ST_Q_SUB,
        ST_OUT
    } state_t;

endpackage

>>> design/semiprime_range_counter.sv
// ----------------------------------------------------------------------------
// Semiprime range counter
// Least-factor sieve and prefix table of semiprime counts, range queries.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis (tuser: kind; tdata: low_end, high_end from
// bit 0). Each item gives one result item on m_axis (tdata: semiprime_total,
// status). The upper limit is written on cfg (cfg_valid/cfg_ready/cfg_data),
// which is ready only while idle; a write clamps the value into
// [4, MAX_LIMIT] and invalidates the tables.
// A build item clears the least-factor memory from 0 to the limit, runs the
// sieve (a read and a check per candidate, a read and a write per crossed-off
// multiple), then fills the prefix table: a number below 4 is written at once,
// a number with no recorded factor is read and written, and a composite also
// has its cofactor found by a one-bit-per-cycle divider and then looked up.
// The build's length is set by the single memory port of each store, which
// one sequencer steps through. A query result takes two prefix reads and a
// subtraction; the next query is taken only after that result is accepted.
// A query before a build or with bad bounds answers the next cycle.
// s_axis_tready is high only while the block is idle. A result waits in the
// output register until m_axis_tready is seen; no new item is taken meanwhile.
// Reset sets the limit to 65536 clamped to MAX_LIMIT and marks the tables
// unbuilt; memory contents are not touched by reset.
// ----------------------------------------------------------------------------
module semiprime_range_counter #(
    parameter int MAX_LIMIT = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // low_end [16:0], high_end [33:17], zero fill above
    input  logic [39:0] s_axis_tdata,
    // kind [0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // semiprime_total [15:0], status [17:16], zero fill above
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    function automatic int floor_sqrt(input int n);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= n)
            r++;
        return r;
    endfunction

    localparam int AW = $clog2(MAX_LIMIT + 1);
    localparam int DEPTH = MAX_LIMIT + 1;
    localparam int LW = (AW > 17) ? AW : 17;
    localparam int BW = $clog2(AW);
    // A stored least factor never exceeds the square root of the limit.
    localparam int FW_RAW = $clog2(floor_sqrt(MAX_LIMIT));
    localparam int FW = (FW_RAW < 2) ? 2 : FW_RAW;
    // The semiprime count up to n stays below n/2.
    localparam int CW = (AW - 1 > 16) ? AW - 1 : 16;
    localparam int RST_LIMIT = (MAX_LIMIT < spc_pkg::RESET_LIMIT) ? MAX_LIMIT
                                                                  : spc_pkg::RESET_LIMIT;

    function automatic logic [15:0] sat16(input logic [CW-1:0] v);
        return (v > CW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
    endfunction

    logic [FW-1:0] lpf_mem [DEPTH];
    logic [CW-1:0] pfx_mem [DEPTH];

    spc_pkg::state_t state_reg, state_next;
    logic [AW-1:0] limit_reg, built_reg;
    logic          built_flag_reg, built_flag_next;
    logic [AW-1:0] i_reg, i_next, k_reg, k_next, hi_reg, hi_next, lo_reg, lo_next;
    logic [CW-1:0] cnt_reg, cnt_next, a_reg, a_next;
    logic [FW-1:0] p_reg, p_next;
    logic [15:0]   res_reg, res_next;
    logic [1:0]    stat_reg, stat_next;

    // Memory ports.
    logic          lpf_we, pfx_we;
    logic [AW-1:0] lpf_addr, pfx_addr;
    logic [FW-1:0] lpf_wdata, lpf_q;
    logic [CW-1:0] pfx_q;

    always_ff @(posedge clk)
    begin
        if (lpf_we)
            lpf_mem[lpf_addr] <= lpf_wdata;
        lpf_q <= lpf_mem[lpf_addr];
        if (pfx_we)
            pfx_mem[pfx_addr] <= cnt_reg;
        pfx_q <= pfx_mem[pfx_addr];
    end

    // Input decode.
    logic          in_kind;
    logic [16:0]   in_lo, in_hi;
    assign in_kind = s_axis_tuser;
    assign in_lo   = s_axis_tdata[16:0];
    assign in_hi   = s_axis_tdata[33:17];

    logic [LW-1:0] cfg_ext, cl_val;
    assign cfg_ext = LW'(cfg_data);
    always_comb
    begin
        if (cfg_ext < LW'(4))
            cl_val = LW'(4);
        else if (cfg_ext > LW'(MAX_LIMIT))
            cl_val = LW'(MAX_LIMIT);
        else
            cl_val = cfg_ext;
    end

    assign s_axis_tready = (state_reg == spc_pkg::ST_IDLE);
    assign cfg_ready     = (state_reg == spc_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == spc_pkg::ST_OUT);
    assign m_axis_tdata  = {6'd0, stat_reg, res_reg};

    // Sieve: i*i computed on a full double-width product.
    logic [2*AW-1:0] isq;
    assign isq = (2*AW)'(i_reg) * (2*AW)'(i_reg);

    // The cofactor i / p comes from a restoring divider, one quotient bit per
    // cycle; the cofactor is prime when its least-factor entry is zero.
    logic [AW-1:0] quo_reg, quo_next, rem_reg, rem_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic [AW:0]   trial;
    assign trial = {rem_reg, i_reg[bit_reg]} - (AW+1)'(p_reg);

    always_comb
    begin
        state_next      = state_reg;
        built_flag_next = built_flag_reg;
        i_next = i_reg; k_next = k_reg; hi_next = hi_reg; lo_next = lo_reg;
        cnt_next = cnt_reg; a_next = a_reg; p_next = p_reg;
        res_next = res_reg; stat_next = stat_reg;
        quo_next = quo_reg; rem_next = rem_reg; bit_next = bit_reg;
        lpf_we = 1'b0; pfx_we = 1'b0;
        lpf_addr = i_reg; pfx_addr = i_reg; lpf_wdata = '0;
        case (state_reg)
            spc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (in_kind == spc_pkg::KIND_BUILD)
                    begin
                        i_next = '0;
                        built_flag_next = 1'b0;
                        state_next = spc_pkg::ST_CLEAR;
                    end
                    else if (!built_flag_reg)
                    begin
                        res_next = '0; stat_next = spc_pkg::STATUS_UNBUILT;
                        state_next = spc_pkg::ST_OUT;
                    end
                    else if (in_lo == 17'd0 || in_lo > in_hi ||
                             LW'(in_hi) > LW'(built_reg))
                    begin
                        res_next = '0; stat_next = spc_pkg::STATUS_BOUNDS;
                        state_next = spc_pkg::ST_OUT;
                    end
                    else
                    begin
                        hi_next = AW'(in_hi);
                        lo_next = AW'(LW'(in_lo) - LW'(1));
                        state_next = spc_pkg::ST_Q_RD_HI;
                    end
                end
            end
            spc_pkg::ST_CLEAR:
            begin
                lpf_we = 1'b1;
                if (i_reg == limit_reg)
                begin
                    i_next = AW'(2);
                    state_next = spc_pkg::ST_OUTER_RD;
                end
                else
                    i_next = i_reg + AW'(1);
            end
            spc_pkg::ST_OUTER_RD:
            begin
                if (isq > (2*AW)'(limit_reg))
                begin
                    i_next = '0;
                    cnt_next = '0;
                    state_next = spc_pkg::ST_PFX_WR;
                end
                else
                    state_next = spc_pkg::ST_OUTER_CHK;
            end
            spc_pkg::ST_OUTER_CHK:
            begin
                if (lpf_q != '0)
                    i_next = i_reg + AW'(1);
                else
                    k_next = AW'(isq);
                state_next = (lpf_q != '0) ? spc_pkg::ST_OUTER_RD
                                           : spc_pkg::ST_INNER_RD;
            end
            spc_pkg::ST_INNER_RD:
            begin
                lpf_addr = k_reg;
                state_next = spc_pkg::ST_INNER_WR;
            end
            spc_pkg::ST_INNER_WR:
            begin
                lpf_addr = k_reg;
                lpf_wdata = FW'(i_reg);
                lpf_we = (lpf_q == '0);
                if ((AW+1)'(k_reg) + (AW+1)'(i_reg) > (AW+1)'(limit_reg))
                begin
                    i_next = i_reg + AW'(1);
                    state_next = spc_pkg::ST_OUTER_RD;
                end
                else
                begin
                    k_next = k_reg + i_reg;
                    state_next = spc_pkg::ST_INNER_RD;
                end
            end
            spc_pkg::ST_PFX_RD:
            begin
                // lpf_q holds the least factor of i.
                if (lpf_q == '0)
                    state_next = spc_pkg::ST_PFX_WR;
                else
                begin
                    p_next = lpf_q;
                    rem_next = '0; quo_next = '0;
                    bit_next = BW'(AW - 1);
                    state_next = spc_pkg::ST_PFX_CO;
                end
            end
            spc_pkg::ST_PFX_CO:
            begin
                if (!trial[AW])
                begin
                    rem_next = trial[AW-1:0];
                    quo_next = {quo_reg[AW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[AW-2:0], i_reg[bit_reg]};
                    quo_next = {quo_reg[AW-2:0], 1'b0};
                end
                if (bit_reg == '0)
                    state_next = spc_pkg::ST_PFX_CF;
                else
                    bit_next = bit_reg - BW'(1);
            end
            spc_pkg::ST_PFX_CF:
            begin
                lpf_addr = quo_reg;
                state_next = spc_pkg::ST_PFX_CHK;
            end
            spc_pkg::ST_PFX_CHK:
            begin
                if (lpf_q == '0)
                    cnt_next = cnt_reg + CW'(1);
                state_next = spc_pkg::ST_PFX_WR;
            end
            spc_pkg::ST_PFX_WR:
            begin
                pfx_we = 1'b1;
                if (i_reg == limit_reg)
                begin
                    built_flag_next = 1'b1;
                    res_next = sat16(cnt_reg); stat_next = spc_pkg::STATUS_OK;
                    state_next = spc_pkg::ST_OUT;
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                    lpf_addr = i_reg + AW'(1);
                    state_next = (i_reg + AW'(1) < AW'(4)) ? spc_pkg::ST_PFX_WR
                                                           : spc_pkg::ST_PFX_RD;
                end
            end
            spc_pkg::ST_Q_RD_HI:
            begin
                pfx_addr = hi_reg;
                state_next = spc_pkg::ST_Q_RD_LO;
            end
            spc_pkg::ST_Q_RD_LO:
            begin
                pfx_addr = lo_reg;
                a_next = pfx_q;
                state_next = spc_pkg::ST_Q_SUB;
            end
            spc_pkg::ST_Q_SUB:
            begin
                res_next = sat16(a_reg - pfx_q);
                stat_next = spc_pkg::STATUS_OK;
                state_next = spc_pkg::ST_OUT;
            end
            spc_pkg::ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = spc_pkg::ST_IDLE;
            end
            default:
                state_next = spc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spc_pkg::ST_IDLE;
            built_flag_reg <= 1'b0;
            limit_reg      <= AW'(RST_LIMIT);
            built_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            built_flag_reg <= (cfg_valid && cfg_ready) ? 1'b0 : built_flag_next;
            if (cfg_valid && cfg_ready)
                limit_reg <= AW'(cl_val);
            if (state_reg == spc_pkg::ST_PFX_WR && i_reg == limit_reg)
                built_reg <= limit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; k_reg <= k_next; hi_reg <= hi_next; lo_reg <= lo_next;
        cnt_reg <= cnt_next; a_reg <= a_next; p_reg <= p_next;
        res_reg <= res_next; stat_reg <= stat_next;
        quo_reg <= quo_next; rem_reg <= rem_next; bit_reg <= bit_next;
    end

endmodule

>>> tb/tb_semiprime_range_counter.sv
// ----------------------------------------------------------------------------
// Semiprime range counter testbench
// Builds the sieve and prefix tables at several upper limits, the extremes
// among them, and fires directed and random range queries at them. A model
// in the bench predicts each count and status, and a checker compares every
// result item with the oldest prediction. Both sides of the stream idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_semiprime_range_counter;

    localparam int LIMIT_CAP = 65536;

    typedef struct packed {
        logic [15:0] total;
        logic [1:0]  status;
    } count_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;

    // Model of the block: least-factor store, prefix counts, limits.
    int          least_factor [0:LIMIT_CAP];
    int          prefix_count [0:LIMIT_CAP];
    bit          model_built;
    int          model_limit;
    int          model_built_limit;

    count_result_t expected_counts[$];
    int          mismatches;
    bit          tx_steady;
    bit          rx_steady;
    int          rx_hold_request;
    int          rx_hold_left;

    semiprime_range_counter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #100000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void sieve_tables(int n);
        int i;
        int k;
        int c;
        for (i = 0; i <= LIMIT_CAP; i++)
            least_factor[i] = 0;
        for (i = 2; i * i <= n; i++)
        begin
            if (least_factor[i] != 0)
                continue;
            for (k = i * i; k <= n; k += i)
                if (least_factor[k] == 0)
                    least_factor[k] = i;
        end
        for (i = 0; i < 4; i++)
            prefix_count[i] = 0;
        for (i = 4; i <= n; i++)
        begin
            c = prefix_count[i - 1];
            if (least_factor[i] != 0 && least_factor[i / least_factor[i]] == 0)
                c++;
            prefix_count[i] = c;
        end
        model_built_limit = n;
        model_built = 1'b1;
    endfunction

    function automatic int saturate16(int v);
        return (v > 65535) ? 65535 : v;
    endfunction

    function automatic count_result_t predict_count(logic kind, int lo, int hi);
        count_result_t r;
        r.total  = '0;
        r.status = spc_pkg::STATUS_OK;
        if (kind == spc_pkg::KIND_BUILD)
        begin
            sieve_tables(model_limit);
            r.total = 16'(saturate16(prefix_count[model_built_limit]));
        end
        else if (!model_built)
            r.status = spc_pkg::STATUS_UNBUILT;
        else if (lo == 0 || lo > hi || hi > model_built_limit)
            r.status = spc_pkg::STATUS_BOUNDS;
        else
            r.total = 16'(saturate16(prefix_count[hi] - prefix_count[lo - 1]));
        return r;
    endfunction

    // Offer one item, with random idle cycles ahead of it, and record the
    // prediction at the edge where it is taken.
    task automatic send_item(logic kind, int lo, int hi);
        while (!tx_steady && $urandom_range(99) < 36)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, hi[16:0], lo[16:0]};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_counts.push_back(predict_count(kind, lo, hi));
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_limit(int value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[16:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        model_limit = (value < 4) ? 4 : (value > LIMIT_CAP) ? LIMIT_CAP : value;
        model_built = 1'b0;
    endtask

    task automatic random_query();
        int lo;
        int hi;
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            hi = $urandom_range(model_limit, 1);
            lo = $urandom_range(hi, 1);
        end
        else if (pick < 85)
        begin
            lo = 0;
            hi = $urandom_range(model_limit, 0);
        end
        else if (pick < 90)
        begin
            hi = $urandom_range(model_limit, 1);
            lo = hi + $urandom_range(20, 1);
        end
        else if (pick < 95)
        begin
            lo = $urandom_range(model_limit, 1);
            hi = model_limit + $urandom_range(50, 1);
        end
        else
        begin
            lo = $urandom_range(131071);
            hi = $urandom_range(131071);
        end
        send_item(spc_pkg::KIND_QUERY, lo, hi);
    endtask

    task automatic test_unbuilt_queries();
        send_item(spc_pkg::KIND_QUERY, 1, 1);
        send_item(spc_pkg::KIND_QUERY, 0, 0);
        send_item(spc_pkg::KIND_QUERY, 131071, 131071);
        send_item(spc_pkg::KIND_QUERY, 4, 65536);
    endtask

    task automatic test_full_limit();
        // Reset limit: one build over the whole store.
        send_item(spc_pkg::KIND_BUILD, 131071, 131071);
        send_item(spc_pkg::KIND_QUERY, 1, 65536);
        send_item(spc_pkg::KIND_QUERY, 4, 4);
        send_item(spc_pkg::KIND_QUERY, 1, 3);
        send_item(spc_pkg::KIND_QUERY, 6, 6);
        send_item(spc_pkg::KIND_QUERY, 7, 7);
        send_item(spc_pkg::KIND_QUERY, 65536, 65536);
        send_item(spc_pkg::KIND_QUERY, 65535, 65536);
        send_item(spc_pkg::KIND_QUERY, 0, 5);
        send_item(spc_pkg::KIND_QUERY, 7, 6);
        send_item(spc_pkg::KIND_QUERY, 1, 65537);
        send_item(spc_pkg::KIND_QUERY, 131071, 131071);
        send_item(spc_pkg::KIND_QUERY, 43690, 87381);
        send_item(spc_pkg::KIND_QUERY, 21845, 43690);
    endtask

    task automatic test_limit_extremes();
        write_limit(0);
        send_item(spc_pkg::KIND_QUERY, 1, 4);
        send_item(spc_pkg::KIND_BUILD, 0, 0);
        send_item(spc_pkg::KIND_QUERY, 4, 4);
        send_item(spc_pkg::KIND_QUERY, 1, 4);
        send_item(spc_pkg::KIND_QUERY, 1, 5);
        write_limit(3);
        send_item(spc_pkg::KIND_BUILD, 0, 0);
        send_item(spc_pkg::KIND_QUERY, 2, 4);
        write_limit(131071);
        send_item(spc_pkg::KIND_QUERY, 1, 10);
        write_limit(65536);
        send_item(spc_pkg::KIND_QUERY, 1, 10);
    endtask

    task automatic test_random_phases();
        int phase;
        int n;
        for (phase = 0; phase < 13; phase++)
        begin
            if ($urandom_range(3) == 0)
                write_limit($urandom_range(3000, 4));
            else
                write_limit($urandom_range(400, 0));
            tx_steady = (phase == 4);
            rx_steady = (phase == 4);
            send_item(spc_pkg::KIND_BUILD, $urandom_range(131071), $urandom_range(131071));
            if (phase == 6)
                rx_hold_request = 300;
            for (n = 0; n < 50; n++)
            begin
                if ($urandom_range(99) < 4)
                    send_item(spc_pkg::KIND_BUILD, $urandom_range(131071),
                              $urandom_range(131071));
                else
                    random_query();
                // Sender waits until the block has answered everything.
                if (phase == 8 && n == 25)
                    drain_results();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_hold_request != 0 || rx_hold_left != 0)
        begin
            if (rx_hold_request != 0)
            begin
                rx_hold_left = rx_hold_request;
                rx_hold_request = 0;
            end
            rx_hold_left = rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rx_steady || ($urandom_range(99) >= 36);
    end

    always @(posedge clk)
    begin
        count_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_counts.size() == 0)
            begin
                $display("%0t: unexpected result item, expected none actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_counts.pop_front();
                if (m_axis_tdata[15:0] !== want.total)
                begin
                    $display("%0t: semiprime_total expected %0d actual %0d",
                             $time, want.total, m_axis_tdata[15:0]);
                    mismatches++;
                end
                if (m_axis_tdata[17:16] !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tdata[17:16]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        m_axis_tready   = 1'b0;
        mismatches      = 0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        rx_hold_request = 0;
        rx_hold_left    = 0;
        model_built     = 1'b0;
        model_limit     = LIMIT_CAP;
        model_built_limit = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_unbuilt_queries();
        test_full_limit();
        test_limit_extremes();
        test_random_phases();

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_counts.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
